// ===== rtl/cmb_pkg.sv =====
// ----------------------------------------------------------------------------
// cmb_pkg: shared types and constants for the colour matrix blend
// Pixel beat structs, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package cmb_pkg;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int COEF_W     = 16;
	localparam int COEF_REG_W = NUM_CH * COEF_W;
	localparam int WEIGHT_W   = 16;
	localparam int CFG_DATA_W = COEF_REG_W;
	localparam int COEF_FRAC  = 12;
	localparam int W_FRAC     = 14;
	localparam int TOTAL_FRAC = COEF_FRAC + W_FRAC;

	// pixel x coefficient, sum of three, blend product, final accumulator
	localparam int PROD_W = 24;
	localparam int DIFF_W = 26;
	localparam int BLND_W = 40;
	localparam int ACC_W  = 40;

	localparam logic [COEF_REG_W-1:0] COEF_OUT0_RST = 48'h0000_0000_1000;
	localparam logic [COEF_REG_W-1:0] COEF_OUT1_RST = 48'h0000_1000_0000;
	localparam logic [COEF_REG_W-1:0] COEF_OUT2_RST = 48'h1000_0000_0000;
	localparam logic [WEIGHT_W-1:0]   WEIGHT_RST    = 16'h0000;

	localparam logic signed [WEIGHT_W-1:0] W_MAX = 16'sd16384;
	localparam logic signed [WEIGHT_W-1:0] W_MIN = -16'sd16384;

	localparam logic signed [ACC_W-1:0] RND_HALF = 40'sd1 <<< (TOTAL_FRAC - 1);

	typedef enum logic [1:0] {
		REG_COEF_OUT0    = 2'd0,
		REG_COEF_OUT1    = 2'd1,
		REG_COEF_OUT2    = 2'd2,
		REG_BLEND_WEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] in_ch0;
		logic [CH_W-1:0] in_ch1;
		logic [CH_W-1:0] in_ch2;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_ch0;
		logic [CH_W-1:0] out_ch1;
		logic [CH_W-1:0] out_ch2;
	} pix_out_t;

endpackage

// ===== rtl/color_matrix_blend.sv =====
// ----------------------------------------------------------------------------
// color_matrix_blend: 3x3 colour correction matrix blended with the pixel
// Throughput: one pixel per clock; busy stays low, nothing ever stalls.
// The rate comes from the four-stage register pipeline: products, matrix sum,
// blend multiply, then round and saturate.
// Reset clears the valid bits and loads the identity matrix with zero weight.
// ----------------------------------------------------------------------------
module color_matrix_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  cmb_pkg::pix_in_t                    pixel,
	output logic                                done,
	output cmb_pkg::pix_out_t                   result,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [cmb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// ---------------------------------------------------------------- config
	logic [cmb_pkg::COEF_REG_W-1:0] coef_q [cmb_pkg::NUM_CH];
	logic [cmb_pkg::WEIGHT_W-1:0]   weight_q;

	// Configuration must only be written while the pipe is empty (the block does not
	// enforce this), so the stages read these registers directly without shadow copies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= cmb_pkg::COEF_OUT0_RST;
			coef_q[1] <= cmb_pkg::COEF_OUT1_RST;
			coef_q[2] <= cmb_pkg::COEF_OUT2_RST;
			weight_q  <= cmb_pkg::WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cmb_pkg::reg_idx_t'(cfg_index))
				cmb_pkg::REG_COEF_OUT0:    coef_q[0] <= cfg_data;
				cmb_pkg::REG_COEF_OUT1:    coef_q[1] <= cfg_data;
				cmb_pkg::REG_COEF_OUT2:    coef_q[2] <= cfg_data;
				cmb_pkg::REG_BLEND_WEIGHT: weight_q  <= cfg_data[cmb_pkg::WEIGHT_W-1:0];
			endcase
		end
	end

	// The pipe never holds back, so every start is a beat.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------------------------------------------------------- valids
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------- stage 1: products
	// Nine small 9x16 signed multiplies, one per input/output channel pair.
	// Clamp the weight to -1.0..+1.0 here as well.
	logic [cmb_pkg::CH_W-1:0]          px_in [cmb_pkg::NUM_CH];
	logic signed [cmb_pkg::WEIGHT_W-1:0] w_raw;
	logic signed [cmb_pkg::WEIGHT_W-1:0] w_clamp;

	assign px_in[0] = pixel.in_ch0;
	assign px_in[1] = pixel.in_ch1;
	assign px_in[2] = pixel.in_ch2;
	assign w_raw    = $signed(weight_q);

	always_comb begin
		priority if (w_raw > cmb_pkg::W_MAX) begin
			w_clamp = cmb_pkg::W_MAX;
		end else if (w_raw < cmb_pkg::W_MIN) begin
			w_clamp = cmb_pkg::W_MIN;
		end else begin
			w_clamp = w_raw;
		end
	end

	logic signed [cmb_pkg::PROD_W-1:0]   prod_s1 [cmb_pkg::NUM_CH][cmb_pkg::NUM_CH];
	logic [cmb_pkg::CH_W-1:0]            px_s1 [cmb_pkg::NUM_CH];
	logic signed [cmb_pkg::WEIGHT_W-1:0] w_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < cmb_pkg::NUM_CH; k++) begin
				px_s1[k] <= px_in[k];
				for (int i = 0; i < cmb_pkg::NUM_CH; i++) begin
					prod_s1[k][i] <= cmb_pkg::PROD_W'(
						$signed({1'b0, px_in[i]}) *
						$signed(coef_q[k][cmb_pkg::COEF_W*i +: cmb_pkg::COEF_W]));
				end
			end
			w_s1 <= w_clamp;
		end
	end

	// ------------------------------------- stage 2: matrix sum minus pixel
	logic signed [cmb_pkg::DIFF_W-1:0]   diff_s2 [cmb_pkg::NUM_CH];
	logic [cmb_pkg::CH_W-1:0]            px_s2 [cmb_pkg::NUM_CH];
	logic signed [cmb_pkg::WEIGHT_W-1:0] w_s2;
	logic signed [cmb_pkg::DIFF_W-1:0]   diff_nxt [cmb_pkg::NUM_CH];

	always_comb begin
		for (int k = 0; k < cmb_pkg::NUM_CH; k++) begin
			diff_nxt[k] = cmb_pkg::DIFF_W'(prod_s1[k][0]) + cmb_pkg::DIFF_W'(prod_s1[k][1])
				+ cmb_pkg::DIFF_W'(prod_s1[k][2])
				- $signed({6'b0, px_s1[k], 12'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			diff_s2 <= diff_nxt;
			px_s2   <= px_s1;
			w_s2    <= w_s1;
		end
	end

	// ------------------------------------------- stage 3: blend multiply
	logic signed [cmb_pkg::BLND_W-1:0] blend_s3 [cmb_pkg::NUM_CH];
	logic [cmb_pkg::CH_W-1:0]          px_s3 [cmb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			for (int k = 0; k < cmb_pkg::NUM_CH; k++) begin
				blend_s3[k] <= cmb_pkg::BLND_W'(w_s2 * diff_s2[k]);
			end
			px_s3 <= px_s2;
		end
	end

	// ------------------------------------ stage 4: round and saturate
	// Add the pixel in Q.26 and half an LSB, then drop the fraction;
	// clamp negatives to 0 and anything past 8 bits to 255.
	logic signed [cmb_pkg::ACC_W-1:0] acc [cmb_pkg::NUM_CH];
	logic [cmb_pkg::CH_W-1:0]         sat [cmb_pkg::NUM_CH];

	always_comb begin
		for (int k = 0; k < cmb_pkg::NUM_CH; k++) begin
			acc[k] = blend_s3[k] + $signed({6'b0, px_s3[k], 26'b0}) + cmb_pkg::RND_HALF;
			priority if (acc[k][cmb_pkg::ACC_W-1]) begin
				sat[k] = '0;
			end else if (|acc[k][cmb_pkg::ACC_W-2:cmb_pkg::TOTAL_FRAC+cmb_pkg::CH_W]) begin
				sat[k] = '1;
			end else begin
				sat[k] = acc[k][cmb_pkg::TOTAL_FRAC +: cmb_pkg::CH_W];
			end
		end
	end

	cmb_pkg::pix_out_t res_s4;

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			res_s4.out_ch0 <= sat[0];
			res_s4.out_ch1 <= sat[1];
			res_s4.out_ch2 <= sat[2];
		end
	end

	assign done   = valid_s4;
	assign result = res_s4;

	// ------------------------------------------------------------ checks
`ifndef SYNTHESIS
	// every result beat traces back to an earlier start
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result beat without a matching start");

	// with zero weight the pixel passes through unchanged
	a_zero_weight_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(weight_q == '0, 4)) |->
			(result.out_ch0 == $past(pixel.in_ch0, 4) &&
			 result.out_ch1 == $past(pixel.in_ch1, 4) &&
			 result.out_ch2 == $past(pixel.in_ch2, 4)))
		else $error("zero weight did not pass pixel through");

	// a start always yields a result beat
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("start lost in pipeline");
`endif

endmodule
